@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the RTL files that check their own logic
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define LTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ltw assertion failed");

// next-cycle implication, checked outside reset
`define LTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ltw assertion failed");

`endif

@@ hdl/ltw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltw_pkg
// Types and constants of the logarithmic tilted window counter
// ----------------------------------------------------------------------------
package ltw_pkg;

  localparam int LEVELS  = 16;
  localparam int IDX_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W   = $clog2(LEVELS + 1);
  localparam int BATCH_W = 24;
  localparam int COUNT_W = 32;
  localparam int USED_W  = 5;

  localparam logic [COUNT_W-1:0] MIN_SUPPORT_RST = 32'd256;

  // input kinds carried on tuser
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_PRUNE  = 1'b1;

  // one window: start batch, end batch, count
  typedef struct packed {
    logic [BATCH_W-1:0] lo;
    logic [BATCH_W-1:0] hi;
    logic [COUNT_W-1:0] cnt;
  } win_t;

  // write command from the sequencer to the level store
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             slot_we;
    win_t             slot;
    logic             buf_we;
    win_t             bufw;
    logic             set_valid;
    logic             set_full;
    logic             clr_full;
    logic             drop_we;
    logic [CNT_W-1:0] drop_from;
  } wr_cmd_t;

  // read data of one level
  typedef struct packed {
    logic valid;
    logic full;
    win_t slot;
    win_t bufw;
  } rd_data_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_PRN,
    ST_SUM,
    ST_FIN
  } state_t;

endpackage

@@ hdl/logarithmic_tilted_window_counter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logarithmic_tilted_window_counter
// Chain of tilted window levels with insert, carry, prune and summary
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in_     | input     | in_tvalid/tready   | tdata batch, count; tuser op
//  out_    | output    | out_tvalid/tready  | tdata totals, levels, flags
//  cfg_    | input     | cfg_valid/ready    | cfg_data min_support
//
//  insert: walks 1 to LEVELS levels, one level per cycle through the shared
//  saturating adder; prune: walks the levels up to the cut point over the
//  same adder; then a summary pass over all LEVELS levels and a final state
//  that loads the output register.
//  reset (rst_n low, synchronous) clears all level flags at once.
//  a stalled output holds the block in its final state; a new transaction is
//  taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module logarithmic_tilted_window_counter
  import ltw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // batch_number[23:0], add_count[55:24]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // slot_total[31:0], buffered_total[63:32],
                                  // levels_used[68:64], emptied[69],
                                  // saturated[70], zero[71]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data    // min_support[31:0]
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  win_t               carry_r, carry_nxt;
  logic               sat_r, sat_nxt;
  logic               emptied_r, emptied_nxt;
  logic               low0_r, low0_nxt;
  logic [COUNT_W-1:0] psum_r, psum_nxt;
  logic [COUNT_W-1:0] stot_r, stot_nxt;
  logic [COUNT_W-1:0] btot_r, btot_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [COUNT_W-1:0] min_support_r;

  logic               out_valid_r;
  logic [71:0]        out_data_r;
  logic               out_load;

  wr_cmd_t            wr;
  rd_data_t           rd;
  logic [IDX_W-1:0]   rd_idx;

  logic [COUNT_W-1:0] a_x, a_y, a_sum;
  logic [COUNT_W-1:0] b_x, b_y, b_sum;
  logic               a_ovf, b_ovf;

  logic               in_accept;
  logic               match;
  logic [CNT_W+USED_W-1:0] used_ext;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign rd_idx    = (state_r == ST_IDLE) ? '0 : cnt_r[IDX_W-1:0];
  assign match     = (rd.slot.lo == carry_r.lo);
  assign used_ext  = {{USED_W{1'b0}}, used_r};

  ltw_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (rd_idx),
    .rd     (rd)
  );

  ltw_satadd u_add_a (.a(a_x), .b(a_y), .sum(a_sum), .ovf(a_ovf));
  ltw_satadd u_add_b (.a(b_x), .b(b_y), .sum(b_sum), .ovf(b_ovf));

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_support_r <= MIN_SUPPORT_RST;
    end else if (cfg_valid && cfg_ready) begin
      min_support_r <= cfg_data;
    end
  end

  // sequencer state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r   <= carry_nxt;
    sat_r     <= sat_nxt;
    emptied_r <= emptied_nxt;
    low0_r    <= low0_nxt;
    psum_r    <= psum_nxt;
    stot_r    <= stot_nxt;
    btot_r    <= btot_nxt;
    used_r    <= used_nxt;
  end

  // next state, store commands and adder operands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    carry_nxt   = carry_r;
    sat_nxt     = sat_r;
    emptied_nxt = emptied_r;
    low0_nxt    = low0_r;
    psum_nxt    = psum_r;
    stot_nxt    = stot_r;
    btot_nxt    = btot_r;
    used_nxt    = used_r;
    out_load    = 1'b0;
    wr          = '0;
    wr.idx      = rd_idx;
    a_x         = rd.slot.cnt;
    a_y         = carry_r.cnt;
    b_x         = btot_r;
    b_y         = rd.bufw.cnt;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sat_nxt     = 1'b0;
          emptied_nxt = 1'b0;
          if (in_tuser[0] == OP_INSERT) begin
            carry_nxt.lo  = in_tdata[23:0];
            carry_nxt.hi  = in_tdata[23:0];
            carry_nxt.cnt = in_tdata[55:24];
            cnt_nxt       = '0;
            state_nxt     = ST_INS;
          end else if (!rd.valid) begin
            // prune on an empty chain: straight to the summary
            cnt_nxt   = '0;
            stot_nxt  = '0;
            btot_nxt  = '0;
            used_nxt  = '0;
            state_nxt = ST_SUM;
          end else begin
            psum_nxt  = rd.slot.cnt;
            low0_nxt  = (rd.slot.cnt < min_support_r);
            cnt_nxt   = CNT_W'(1);
            state_nxt = ST_PRN;
          end
        end
      end

      ST_INS: begin
        a_x = rd.slot.cnt;
        a_y = match ? carry_r.cnt : rd.bufw.cnt;
        if (!rd.valid) begin
          // free level takes the window
          wr.slot_we   = 1'b1;
          wr.slot      = carry_r;
          wr.set_valid = 1'b1;
          wr.clr_full  = 1'b1;
          state_nxt    = ST_SUM;
        end else if (match) begin
          // same start batch: add into the slot
          wr.slot_we  = 1'b1;
          wr.slot     = rd.slot;
          wr.slot.cnt = a_sum;
          sat_nxt     = sat_r | a_ovf;
          state_nxt   = ST_SUM;
        end else if (!rd.full) begin
          // empty buffer takes the old slot
          wr.buf_we   = 1'b1;
          wr.bufw     = rd.slot;
          wr.set_full = 1'b1;
          wr.slot_we  = 1'b1;
          wr.slot     = carry_r;
          state_nxt   = ST_SUM;
        end else begin
          // merge slot and buffer, carry upward (the top level keeps the merge in its buffer)
          wr.slot_we = 1'b1;
          wr.slot    = carry_r;
          sat_nxt    = sat_r | a_ovf;
          if (cnt_r == CNT_W'(LEVELS - 1)) begin
            wr.buf_we   = 1'b1;
            wr.bufw.lo  = (rd.slot.lo < rd.bufw.lo) ? rd.slot.lo : rd.bufw.lo;
            wr.bufw.hi  = (rd.slot.hi > rd.bufw.hi) ? rd.slot.hi : rd.bufw.hi;
            wr.bufw.cnt = a_sum;
            sat_nxt     = 1'b1;
            state_nxt   = ST_SUM;
          end else begin
            wr.clr_full   = 1'b1;
            carry_nxt.lo  = (rd.slot.lo < rd.bufw.lo) ? rd.slot.lo : rd.bufw.lo;
            carry_nxt.hi  = (rd.slot.hi > rd.bufw.hi) ? rd.slot.hi : rd.bufw.hi;
            carry_nxt.cnt = a_sum;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end
        end
        if (state_nxt == ST_SUM) begin
          cnt_nxt  = '0;
          stot_nxt = '0;
          btot_nxt = '0;
          used_nxt = '0;
        end
      end

      ST_PRN: begin
        a_x = psum_r;
        a_y = rd.slot.cnt;
        if ((cnt_r == CNT_W'(LEVELS)) || !rd.valid ||
            ((a_sum < min_support_r) && (rd.slot.cnt < min_support_r))) begin
          // cut the tail here, or everything when level 0 is weak
          wr.drop_we   = 1'b1;
          wr.drop_from = low0_r ? '0 : cnt_r;
          emptied_nxt  = low0_r;
          cnt_nxt      = '0;
          stot_nxt     = '0;
          btot_nxt     = '0;
          used_nxt     = '0;
          state_nxt    = ST_SUM;
        end else begin
          psum_nxt = a_sum;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end

      ST_SUM: begin
        // one level per cycle into the running totals
        a_x = stot_r;
        a_y = rd.slot.cnt;
        b_x = btot_r;
        b_y = rd.bufw.cnt;
        if (rd.valid) begin
          used_nxt = used_r + CNT_W'(1);
          stot_nxt = a_sum;
          if (rd.full) btot_nxt = b_sum;
        end
        if (cnt_r == CNT_W'(LEVELS - 1)) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {1'b0, sat_r, emptied_r, used_ext[USED_W-1:0], btot_r, stot_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks on sequencer and result consistency
  `LTW_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `LTW_ASSERT_NOW(a_flags_exclusive, out_tvalid, !(out_tdata[69] && out_tdata[70]))
  `LTW_ASSERT_NOW(a_emptied_is_empty, out_tvalid && out_tdata[69],
                  (out_tdata[68:64] == 5'd0) && (out_tdata[31:0] == 32'd0))

endmodule

@@ hdl/ltw_satadd.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltw_satadd
// Saturating unsigned count adder, clamps at all ones
// ----------------------------------------------------------------------------
module ltw_satadd
  import ltw_pkg::*;
(
  input  logic [COUNT_W-1:0] a,
  input  logic [COUNT_W-1:0] b,
  output logic [COUNT_W-1:0] sum,
  output logic               ovf
);

  logic [COUNT_W:0] raw;

  // add with carry out, clamp on overflow
  assign raw = {1'b0, a} + {1'b0, b};
  assign ovf = raw[COUNT_W];
  assign sum = ovf ? {COUNT_W{1'b1}} : raw[COUNT_W-1:0];

endmodule

@@ hdl/ltw_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltw_store
// Level state: valid and full flags, slot and buffer windows per level
// ----------------------------------------------------------------------------
module ltw_store
  import ltw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  wr_cmd_t          wr,
  input  logic [IDX_W-1:0] rd_idx,
  output rd_data_t         rd
);

  logic [LEVELS-1:0] valid_r;
  logic [LEVELS-1:0] full_r;
  win_t              slot_r [LEVELS];
  win_t              buf_r  [LEVELS];

  // flags: per-level set/clear, plus tail drop on prune
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      full_r  <= '0;
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        if (wr.drop_we && (CNT_W'(i) >= wr.drop_from)) begin
          valid_r[i] <= 1'b0;
          full_r[i]  <= 1'b0;
        end else if (IDX_W'(i) == wr.idx) begin
          if (wr.set_valid) valid_r[i] <= 1'b1;
          if (wr.set_full) begin
            full_r[i] <= 1'b1;
          end else if (wr.clr_full) begin
            full_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  // window payload, no reset
  always_ff @(posedge clk) begin
    if (wr.slot_we) slot_r[wr.idx] <= wr.slot;
    if (wr.buf_we)  buf_r[wr.idx]  <= wr.bufw;
  end

  // single read port at the sequencer index
  always_comb begin
    rd.valid = valid_r[rd_idx];
    rd.full  = full_r[rd_idx];
    rd.slot  = slot_r[rd_idx];
    rd.bufw  = buf_r[rd_idx];
  end

endmodule
